// File: src/bitmap_block_allocator_macros.svh
// Assertion helpers for the bitmap block allocator.
// Both forms sample on the rising edge of clock and are off while reset is high.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define BBA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BBA_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);
`else
`define BBA_ASSERT(label, prop, msg)
`define BBA_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

// File: src/bba_pkg.sv
package bba_pkg;

   // fixed field widths
   localparam int OPCODE_W    = 2;
   localparam int BLOCK_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   // parameter defaults
   localparam int DEF_MAX_BLOCKS    = 4096;
   localparam int DEF_MAP_WORD_BITS = 64;

   // register reset values
   localparam logic [COUNT_W-1:0] TOTAL_RESET    = COUNT_W'(4096);
   localparam logic [COUNT_W-1:0] RESERVED_RESET = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOTAL    = 1'b0,
      CSR_RESERVED = 1'b1
   } csr_index_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_TEST    = 2'd2,
      OP_FORMAT  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_BIT,
      S_FMT,
      S_RESP
   } state_type;

endpackage

// File: src/bba_ram.sv
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bba_word_unit.sv
// Word-wide bit unit: range mask, lowest free bit, set, clear and bit read.
module bba_word_unit #(
   parameter int WORD_BITS = 64,
   parameter int LIM_W     = 13,
   parameter int BIT_W     = $clog2(WORD_BITS)
) (
   input  logic [WORD_BITS-1:0] word_i,
   input  logic [LIM_W-1:0]     lim_i,
   input  logic [BIT_W-1:0]     bit_idx_i,
   output logic [WORD_BITS-1:0] range_mask_o,
   output logic                 found_o,
   output logic [BIT_W-1:0]     free_idx_o,
   output logic [WORD_BITS-1:0] set_word_o,
   output logic [WORD_BITS-1:0] clr_word_o,
   output logic                 bit_o
);

   logic [WORD_BITS-1:0] free_vec;
   logic [WORD_BITS-1:0] lowest;

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         range_mask_o[i] = (lim_i > LIM_W'(i));
      end
   end

   // isolate the lowest free bit with one add
   assign free_vec = ~word_i & range_mask_o;
   assign lowest   = free_vec & (~free_vec + WORD_BITS'(1));
   assign found_o  = |free_vec;

   always_comb begin
      free_idx_o = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowest[i]) begin
            free_idx_o = free_idx_o | BIT_W'(i);
         end
      end
   end

   assign set_word_o = word_i | lowest;
   assign clr_word_o = word_i & ~(WORD_BITS'(1) << bit_idx_i);
   assign bit_o      = word_i[bit_idx_i];

endmodule

// File: src/bitmap_block_allocator.sv
// Path from request transfer to result valid: allocate issues the read of word 0 with the
// transfer, then scans up to ceil(total/MAP_WORD_BITS) words in S_ALLOC; release and test
// pass through S_BIT; format rewrites the ceil(res/W) reserved words in S_FMT. Out-of-range
// numbers, a zero free count and a zero total go straight to the result state S_RESP.
// One request at a time: the next is taken the cycle after the result transfer. The scan
// rate is one bitmap word per cycle, set by the single read port of the bitmap RAM.
// Reset (synchronous, active high) clears the bitmap valid bits, the free count to zero and
// the registers to total 4096, reserved 0; no clearing pass is needed.
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator #(
   parameter int MAX_BLOCKS    = bba_pkg::DEF_MAX_BLOCKS,
   parameter int MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bba_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [bba_pkg::BLOCK_W-1:0]        req_block_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bba_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bba_pkg::BLOCK_W-1:0]        rsp_result_block,
   output logic                               rsp_bit_value,
   output logic [bba_pkg::COUNT_W-1:0]        rsp_free_count,
   input  logic                               csr_we,
   input  logic [bba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import bba_pkg::*;

   // MAP_WORD_BITS is taken as a power of two
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);
   localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CLOG_MAX  = $clog2(MAX_BLOCKS);
   localparam int BLK_W     = (CLOG_MAX + 1 > COUNT_W) ? CLOG_MAX + 1 : COUNT_W;

   // configuration registers
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] reserved_ff, reserved_in;

   // sequencer and result registers
   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [WIDX_W-1:0]       k_ff, k_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [MAP_WORDS-1:0]    valid_ff, valid_in;
   logic [COUNT_W-1:0]      free_ff, free_in;
   status_type              status_ff, status_in;
   logic [BLOCK_W-1:0]      result_ff, result_in;
   logic                    bitv_ff, bitv_in;

   // derived values
   logic [BLK_W-1:0]        eff_tot, eff_res;
   logic [BLK_W-1:0]        base, next_base, lim, bn_ext, alloc_blk;
   logic [WIDX_W:0]         k_inc;
   logic [WIDX_W-1:0]       k_next;
   logic [WIDX_W-1:0]       bn_word;
   logic [BIT_W-1:0]        bn_bit;

   // bitmap RAM
   logic                     ram_we;
   logic [WIDX_W-1:0]        ram_waddr, ram_raddr;
   logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata, word_eff;

   // word unit
   logic [MAP_WORD_BITS-1:0] range_mask, set_word, clr_word;
   logic                     free_found, bit_value;
   logic [BIT_W-1:0]         free_idx;

   bba_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS),
      .ADDR_W(WIDX_W)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   bba_word_unit #(
      .WORD_BITS(MAP_WORD_BITS),
      .LIM_W    (BLK_W),
      .BIT_W    (BIT_W)
   ) u_unit (
      .word_i      (word_eff),
      .lim_i       (lim),
      .bit_idx_i   (bit_ff),
      .range_mask_o(range_mask),
      .found_o     (free_found),
      .free_idx_o  (free_idx),
      .set_word_o  (set_word),
      .clr_word_o  (clr_word),
      .bit_o       (bit_value)
   );

   // total clips at MAX_BLOCKS, reserve clips at the total
   assign eff_tot = (BLK_W'(total_ff) > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS)
                                                           : BLK_W'(total_ff);
   assign eff_res = (BLK_W'(reserved_ff) > eff_tot) ? eff_tot : BLK_W'(reserved_ff);

   assign base      = BLK_W'({k_ff, {BIT_W{1'b0}}});
   assign k_inc     = (WIDX_W + 1)'(k_ff) + (WIDX_W + 1)'(1);
   assign k_next    = k_inc[WIDX_W-1:0];
   assign next_base = BLK_W'({k_inc, {BIT_W{1'b0}}});
   assign lim       = ((state_ff == S_FMT) ? eff_res : eff_tot) - base;
   assign alloc_blk = base + BLK_W'(free_idx);

   assign bn_ext  = BLK_W'(req_block_number);
   assign bn_word = bn_ext[BIT_W +: WIDX_W];
   assign bn_bit  = req_block_number[BIT_W-1:0];

   // a word never written since format or reset reads as all free
   assign word_eff = rd_valid_ff ? ram_rdata : '0;

   // configuration writes
   always_comb begin
      total_in    = total_ff;
      reserved_in = reserved_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TOTAL:    total_in    = csr_wdata;
            CSR_RESERVED: reserved_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= TOTAL_RESET;
         reserved_ff <= RESERVED_RESET;
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         free_ff     <= '0;
      end else begin
         total_ff    <= total_in;
         reserved_ff <= reserved_in;
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         free_ff     <= free_in;
      end
      op_ff       <= op_in;
      k_ff        <= k_in;
      bit_ff      <= bit_in;
      rd_valid_ff <= rd_valid_in;
      status_ff   <= status_in;
      result_ff   <= result_in;
      bitv_ff     <= bitv_in;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      k_in        = k_ff;
      bit_in      = bit_ff;
      rd_valid_in = rd_valid_ff;
      valid_in    = valid_ff;
      free_in     = free_ff;
      status_in   = status_ff;
      result_in   = result_ff;
      bitv_in     = bitv_ff;
      ram_we      = 1'b0;
      ram_waddr   = k_ff;
      ram_wdata   = set_word;
      ram_raddr   = k_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = op_type'(req_opcode);
               status_in = ST_OK;
               bitv_in   = 1'b0;
               result_in = '0;
               unique case (op_type'(req_opcode)) inside
                  OP_ALLOC: begin
                     if (free_ff == '0 || eff_tot == '0) begin
                        status_in = ST_NO_FREE;
                        state_in  = S_RESP;
                     end else begin
                        // issue the read of word 0 with the transfer
                        k_in        = '0;
                        ram_raddr   = '0;
                        rd_valid_in = valid_ff[0];
                        state_in    = S_ALLOC;
                     end
                  end
                  OP_RELEASE, OP_TEST: begin
                     result_in = req_block_number;
                     if (bn_ext >= eff_tot) begin
                        status_in = ST_RANGE;
                        state_in  = S_RESP;
                     end else begin
                        k_in        = bn_word;
                        bit_in      = bn_bit;
                        ram_raddr   = bn_word;
                        rd_valid_in = valid_ff[bn_word];
                        state_in    = S_BIT;
                     end
                  end
                  OP_FORMAT: begin
                     // drop every word at once; reserved words are rewritten below
                     valid_in = '0;
                     k_in     = '0;
                     state_in = S_FMT;
                  end
                  default: ;
               endcase
            end
         end
         S_ALLOC: begin
            if (free_found) begin
               ram_we          = 1'b1;
               ram_wdata       = set_word;
               valid_in[k_ff]  = 1'b1;
               free_in         = free_ff - COUNT_W'(1);
               result_in       = alloc_blk[BLOCK_W-1:0];
               state_in        = S_RESP;
            end else if (next_base >= eff_tot) begin
               status_in = ST_NO_FREE;
               state_in  = S_RESP;
            end else begin
               // advance: next word read overlaps this check
               k_in        = k_next;
               ram_raddr   = k_next;
               rd_valid_in = valid_ff[k_next];
            end
         end
         S_BIT: begin
            if (op_ff == OP_TEST) begin
               bitv_in = bit_value;
            end else begin
               ram_we         = 1'b1;
               ram_wdata      = clr_word;
               valid_in[k_ff] = 1'b1;
               if (BLK_W'(free_ff) < eff_tot) begin
                  free_in = free_ff + COUNT_W'(1);
               end
            end
            state_in = S_RESP;
         end
         S_FMT: begin
            if (base < eff_res) begin
               ram_we         = 1'b1;
               ram_wdata      = range_mask;
               valid_in[k_ff] = 1'b1;
            end
            if (base >= eff_res || next_base >= eff_res) begin
               free_in  = COUNT_W'(eff_tot - eff_res);
               state_in = S_RESP;
            end else begin
               k_in = k_next;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_status       = status_ff;
   assign rsp_result_block = result_ff;
   assign rsp_bit_value    = bitv_ff;
   assign rsp_free_count   = free_ff;

   `BBA_ASSERT(a_one_side_open, !(req_ready && rsp_valid), "ready while result pending")
   `BBA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready after transfer")
   `BBA_ASSERT(a_scan_in_range, (state_ff == S_ALLOC) |-> (base < eff_tot), "scan past total")
   `BBA_ASSERT(a_bit_only_test, (rsp_valid && rsp_bit_value) |-> (op_ff == OP_TEST), "stray bit")
   `BBA_ASSERT_NEXT(a_count_dec, (state_ff == S_ALLOC) && free_found,
                    free_ff == $past(free_ff) - COUNT_W'(1), "count not decremented")

endmodule
